[rtl/dq_pkg.sv]
// Shared types, codes and widths for the double-ended queue core.
package dq_pkg;

    localparam int DEFAULT_DEPTH = 1024;
    localparam int WORD_W        = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 11;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 48;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_SIZE       = 3'd6,
        OP_CLEAR      = 3'd7
    } t_dq_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_dq_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
        logic load;
    } t_dq_cmd;

endpackage

[rtl/dq_ctrl.sv]
// Sequencing controller: input handshake, execute step and output register valid.
module dq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output dq_pkg::t_dq_cmd o_cmd
);
    import dq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    t_state r_state;
    logic   r_m_valid;
    logic   w_load;

    assign w_load     = (r_state == S_LOAD) && (!r_m_valid || i_m_tready);
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

    assign o_cmd.latch = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.exec  = (r_state == S_EXEC);
    assign o_cmd.load  = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    // hold the result until the output register frees up
                    if (w_load) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

endmodule

[rtl/dq_datapath.sv]
// Datapath: ring buffer memory, end pointers, fill count and result registers.
module dq_datapath #(
    parameter int DEPTH = dq_pkg::DEFAULT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dq_pkg::t_dq_cmd               i_cmd,
    input  logic [dq_pkg::OP_W-1:0]       i_op,
    input  logic [dq_pkg::WORD_W-1:0]     i_value,
    output logic [dq_pkg::STATUS_W-1:0]   o_status,
    output logic [dq_pkg::WORD_W-1:0]     o_data,
    output logic [dq_pkg::COUNT_W-1:0]    o_count
);
    import dq_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

    logic [WORD_W-1:0] r_mem [DEPTH];

    logic [OP_W-1:0]     r_op;
    logic [WORD_W-1:0]   r_value;
    logic [ADDR_W-1:0]   r_head, n_head;
    logic [ADDR_W-1:0]   r_tail, n_tail;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [WORD_W-1:0]   r_rd_data;
    logic                r_use_mem, n_use_mem;
    t_dq_status          r_res_status, n_res_status;
    logic [COUNT_W-1:0]  r_res_count;
    logic [STATUS_W-1:0] r_out_status;
    logic [WORD_W-1:0]   r_out_data;
    logic [COUNT_W-1:0]  r_out_count;

    logic [ADDR_W-1:0] w_head_inc, w_head_dec, w_tail_inc, w_tail_dec;
    logic [ADDR_W-1:0] w_rd_addr, w_wr_addr;
    logic              w_wr_en;
    logic              w_empty, w_full;

    assign w_head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign w_head_dec = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign w_tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign w_tail_dec = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
    assign w_empty    = (r_fill == '0);
    assign w_full     = (r_fill >= FULL_FILL);

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_fill       = r_fill;
        n_use_mem    = 1'b0;
        n_res_status = ST_OK;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_tail;
        w_rd_addr    = r_head;
        unique case (t_dq_op'(r_op))
            OP_PUSH_FRONT: begin
                w_wr_addr = w_head_dec;
                if (w_full) begin
                    n_res_status = ST_FULL;
                end else begin
                    w_wr_en = 1'b1;
                    n_head  = w_head_dec;
                    n_fill  = r_fill + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (w_full) begin
                    n_res_status = ST_FULL;
                end else begin
                    w_wr_en = 1'b1;
                    n_tail  = w_tail_inc;
                    n_fill  = r_fill + 1'b1;
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (w_empty) begin
                    n_res_status = ST_EMPTY;
                end else begin
                    n_use_mem = 1'b1;
                    if (r_op == OP_POP_FRONT) begin
                        n_head = w_head_inc;
                        n_fill = r_fill - 1'b1;
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                w_rd_addr = w_tail_dec;
                if (w_empty) begin
                    n_res_status = ST_EMPTY;
                end else begin
                    n_use_mem = 1'b1;
                    if (r_op == OP_POP_BACK) begin
                        n_tail = w_tail_dec;
                        n_fill = r_fill - 1'b1;
                    end
                end
            end
            OP_SIZE: begin
            end
            OP_CLEAR: begin
                n_head = '0;
                n_tail = '0;
                n_fill = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr_en) r_mem[w_wr_addr] <= r_value;
        if (i_cmd.exec) r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_use_mem    <= n_use_mem;
            r_res_status <= n_res_status;
            r_res_count  <= COUNT_W'(n_fill);
        end
        if (i_cmd.load) begin
            r_out_status <= r_res_status;
            r_out_data   <= r_use_mem ? r_rd_data : '0;
            r_out_count  <= r_res_count;
        end
    end

    assign o_status = r_out_status;
    assign o_data   = r_out_data;
    assign o_count  = r_out_count;

    logic [FILL_W:0] w_span;
    assign w_span = {1'b0, FILL_W'(r_head)} + {1'b0, r_fill};

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_FILL)
        else $error("fill count exceeds depth");

    a_ptr_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_span == {1'b0, FILL_W'(r_tail)}) ||
        (w_span == {1'b0, FILL_W'(r_tail)} + {1'b0, FULL_FILL}))
        else $error("head, tail and fill disagree");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_full &&
         (r_op == OP_PUSH_FRONT || r_op == OP_PUSH_BACK))
        |=> ($stable(r_fill) && $stable(r_head) && $stable(r_tail)))
        else $error("push into full queue changed state");

endmodule

[rtl/double_ended_queue_core.sv]
// Double-ended queue core: stream command in, one result transfer out per command.
//
// Input channel: i_s_tuser carries the command (push/pop/peek at either end,
// size, clear) and i_s_tdata the word to push. Output channel: o_m_tuser
// carries the status (ok, empty, full) and o_m_tdata the popped or peeked
// word plus the fill count after the command.
// Each command gives exactly one result transfer.
// Each command goes through accept, execute with a registered memory read
// and the output register load, in that order; a new command is accepted
// only once the previous command has loaded its result.
// The next command is accepted while a result still waits in the output
// register; when the receiver stalls, that command finishes its execute step
// and holds its result until the output register frees, and o_s_tready stays
// low meanwhile.
// Reset clears the pointers and the fill count, so the queue starts empty;
// the storage is not cleared, since only written entries are ever read.
module double_ended_queue_core #(
    parameter int DEPTH = dq_pkg::DEFAULT_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [31:0] value
    input  logic [dq_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [2:0] op
    input  logic [dq_pkg::OP_W-1:0]        i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] data, [42:32] count, [47:43] zero
    output logic [dq_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // [1:0] status
    output logic [dq_pkg::STATUS_W-1:0]    o_m_tuser
);
    import dq_pkg::*;

    t_dq_cmd             w_cmd;
    logic [WORD_W-1:0]   w_data;
    logic [COUNT_W-1:0]  w_count;

    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_op     (i_s_tuser),
        .i_value  (i_s_tdata[WORD_W-1:0]),
        .o_status (o_m_tuser),
        .o_data   (w_data),
        .o_count  (w_count)
    );

    assign o_m_tdata = {(M_TDATA_W - WORD_W - COUNT_W)'(0), w_count, w_data};

endmodule
